// ----- src/leb_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package leb_pkg;
  localparam int LineMax = 64;
  localparam int PosW = 7;
  localparam int AddrW = 6;

  typedef logic [PosW-1:0] pos_t;
  localparam pos_t PosOne = 7'd1;
  localparam pos_t PosMax = 7'd64;

  typedef enum logic [3:0] {
    KIND_INSERT = 4'd0, KIND_LEFT = 4'd1, KIND_RIGHT = 4'd2, KIND_HOME = 4'd3,
    KIND_END = 4'd4, KIND_WLEFT = 4'd5, KIND_WRIGHT = 4'd6, KIND_DEL = 4'd7,
    KIND_BKSP = 4'd8, KIND_DELWORD = 4'd9, KIND_KILLEND = 4'd10,
    KIND_KILLSTART = 4'd11, KIND_CLEAR = 4'd12, KIND_READOUT = 4'd13,
    KIND_NOP14 = 4'd14, KIND_NOP15 = 4'd15
  } kind_e;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SETUP, ST_SCANL_WS, ST_SCANL_WD, ST_SCANR_WD, ST_SCANR_WS,
    ST_SCAN_END, ST_SHIFT_UP, ST_SHIFT_DN, ST_READ, ST_FINISH
  } state_e;

  // Controller to datapath.
  typedef struct packed {
    logic load;        // latch command on accept
    logic setup;       // prepare pointers and next cursor/length
    logic rd_left;     // read store at scan pointer minus one
    logic rd_here;     // read store at scan pointer
    logic rd_far;      // read store at scan pointer plus gap
    logic step_dn;     // scan pointer minus one
    logic step_up;     // scan pointer plus one
    logic shift_up;    // write read data at p, then p minus one (insert gap)
    logic shift_dn;    // write read data at p, then p plus one (close gap)
    logic write_ch;    // write inserted character at cursor
    logic cut_setup;   // prepare the cut after a word scan
    logic take_p;      // next cursor is the scan pointer
    logic finish;      // apply cursor/length and emit one result
    logic emit_char;   // emit one readout beat
  } ctl_t;

  // Datapath to controller.
  typedef struct packed {
    logic [3:0] kind;
    logic       p_zero;    // scan pointer at 0
    logic       p_at_len;  // scan pointer at length
    logic       rd_ws;     // registered read data is whitespace
    logic       shift_end; // gap closing reached end
    logic       up_end;    // gap opening reached cursor
    logic       ins_ok;
    logic       need_shift_dn;
    logic       len_zero;
    logic       last_char;
  } sts_t;

  function automatic logic is_ws(input logic [7:0] c);
    return (c >= 8'h09 && c <= 8'h0D) || c == 8'h20;
  endfunction
endpackage
`default_nettype wire

// ----- src/line_edit_buffer_engine.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Line editor: one command per start beat while busy is low. Each command
// gives one result beat on result_valid_o; readout gives one beat per
// character (or one beat for an empty line). The receiver cannot stall.
// Busy stays high from the accepting edge until the last result beat is on
// the outputs, and is low again in that cycle. Moves, kills to the end, clear
// and unused kinds go from setup straight to finish. Inserts and deletions
// move the text store one entry at a time (read, then write), word scans read
// and then test one character at a time, and readout reads each character
// before it gives its beat.
module line_edit_buffer_engine (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       start,
  output logic            busy,
  input  wire logic [3:0] kind_i,
  input  wire logic [7:0] char_code_i,
  input  wire logic       max_len_we_i,
  input  wire logic [6:0] max_len_i,
  output logic            result_valid_o,
  output logic            changed_o,
  output logic [6:0]      cursor_pos_o,
  output logic [6:0]      text_len_o,
  output logic [7:0]      char_out_o,
  output logic            last_o
);
  leb_pkg::ctl_t ctl;
  leb_pkg::sts_t sts;

  leb_ctrl u_ctrl (
    .clk_i, .rst_ni, .start, .busy, .sts_i(sts), .ctl_o(ctl)
  );

  leb_dp u_dp (
    .clk_i, .rst_ni, .kind_i, .char_code_i, .max_len_we_i, .max_len_i,
    .ctl_i(ctl), .sts_o(sts), .res_valid_o(result_valid_o), .changed_o,
    .cursor_pos_o, .text_len_o, .char_out_o, .last_o
  );
endmodule
`default_nettype wire

// ----- src/leb_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
module leb_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start,
  output logic               busy,
  input  wire leb_pkg::sts_t sts_i,
  output leb_pkg::ctl_t      ctl_o
);
  leb_pkg::state_e state_q, state_d;

  // Store accesses issue a read, then use the registered data in the next cycle: a phase bit.
  logic ph_q, ph_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= leb_pkg::ST_IDLE;
      ph_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      ph_q    <= ph_d;
    end
  end

  assign busy = (state_q != leb_pkg::ST_IDLE);

  always_comb begin
    state_d = state_q;
    ph_d    = 1'b0;
    case (state_q)
      leb_pkg::ST_IDLE: begin
        if (start) state_d = leb_pkg::ST_SETUP;
      end
      leb_pkg::ST_SETUP: begin
        case (sts_i.kind)
          leb_pkg::KIND_WLEFT, leb_pkg::KIND_DELWORD: state_d = leb_pkg::ST_SCANL_WS;
          leb_pkg::KIND_WRIGHT: state_d = leb_pkg::ST_SCANR_WD;
          leb_pkg::KIND_INSERT:
            state_d = sts_i.ins_ok ? leb_pkg::ST_SHIFT_UP : leb_pkg::ST_FINISH;
          leb_pkg::KIND_DEL, leb_pkg::KIND_BKSP, leb_pkg::KIND_KILLSTART:
            state_d = sts_i.need_shift_dn ? leb_pkg::ST_SHIFT_DN : leb_pkg::ST_FINISH;
          leb_pkg::KIND_READOUT:
            state_d = sts_i.len_zero ? leb_pkg::ST_FINISH : leb_pkg::ST_READ;
          default: state_d = leb_pkg::ST_FINISH;
        endcase
      end
      leb_pkg::ST_SCANL_WS: begin
        if (!ph_q) begin
          if (sts_i.p_zero) state_d = leb_pkg::ST_SCAN_END;
          else ph_d = 1'b1;
        end else if (!sts_i.rd_ws) begin
          // The word character just read is tested again in the word phase.
          state_d = leb_pkg::ST_SCANL_WD;
          ph_d    = 1'b1;
        end
      end
      leb_pkg::ST_SCANL_WD: begin
        if (!ph_q) begin
          if (sts_i.p_zero) state_d = leb_pkg::ST_SCAN_END;
          else ph_d = 1'b1;
        end else if (sts_i.rd_ws) begin
          state_d = leb_pkg::ST_SCAN_END;
        end
      end
      leb_pkg::ST_SCANR_WD: begin
        if (!ph_q) begin
          if (sts_i.p_at_len) state_d = leb_pkg::ST_SCAN_END;
          else ph_d = 1'b1;
        end else if (sts_i.rd_ws) begin
          state_d = leb_pkg::ST_SCANR_WS;
          ph_d    = 1'b1;
        end
      end
      leb_pkg::ST_SCANR_WS: begin
        if (!ph_q) begin
          if (sts_i.p_at_len) state_d = leb_pkg::ST_SCAN_END;
          else ph_d = 1'b1;
        end else if (!sts_i.rd_ws) begin
          state_d = leb_pkg::ST_SCAN_END;
        end
      end
      leb_pkg::ST_SCAN_END: begin
        state_d = (sts_i.kind == leb_pkg::KIND_DELWORD) ? leb_pkg::ST_SHIFT_DN
                                                         : leb_pkg::ST_FINISH;
      end
      leb_pkg::ST_SHIFT_UP: begin
        if (!ph_q) begin
          if (sts_i.up_end) state_d = leb_pkg::ST_FINISH;
          else ph_d = 1'b1;
        end
      end
      leb_pkg::ST_SHIFT_DN: begin
        if (!ph_q) begin
          if (sts_i.shift_end) state_d = leb_pkg::ST_FINISH;
          else ph_d = 1'b1;
        end
      end
      leb_pkg::ST_READ: begin
        if (!ph_q) ph_d = 1'b1;
        else if (sts_i.last_char) state_d = leb_pkg::ST_IDLE;
      end
      leb_pkg::ST_FINISH: state_d = leb_pkg::ST_IDLE;
      default: state_d = leb_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ctl_o = '0;
    case (state_q)
      leb_pkg::ST_IDLE: ctl_o.load = start;
      leb_pkg::ST_SETUP: ctl_o.setup = 1'b1;
      leb_pkg::ST_SCANL_WS: begin
        if (!ph_q) ctl_o.rd_left = !sts_i.p_zero;
        else ctl_o.step_dn = sts_i.rd_ws;
      end
      leb_pkg::ST_SCANL_WD: begin
        if (!ph_q) ctl_o.rd_left = !sts_i.p_zero;
        else ctl_o.step_dn = !sts_i.rd_ws;
      end
      leb_pkg::ST_SCANR_WD: begin
        if (!ph_q) ctl_o.rd_here = !sts_i.p_at_len;
        else ctl_o.step_up = !sts_i.rd_ws;
      end
      leb_pkg::ST_SCANR_WS: begin
        if (!ph_q) ctl_o.rd_here = !sts_i.p_at_len;
        else ctl_o.step_up = sts_i.rd_ws;
      end
      leb_pkg::ST_SCAN_END: begin
        if (sts_i.kind == leb_pkg::KIND_DELWORD) ctl_o.cut_setup = 1'b1;
        else ctl_o.take_p = 1'b1;
      end
      leb_pkg::ST_SHIFT_UP: begin
        if (!ph_q) begin
          ctl_o.rd_left  = !sts_i.up_end;
          ctl_o.write_ch = sts_i.up_end;
        end else begin
          ctl_o.shift_up = 1'b1;
        end
      end
      leb_pkg::ST_SHIFT_DN: begin
        if (!ph_q) ctl_o.rd_far = !sts_i.shift_end;
        else ctl_o.shift_dn = 1'b1;
      end
      leb_pkg::ST_READ: begin
        if (!ph_q) ctl_o.rd_here = 1'b1;
        else ctl_o.emit_char = 1'b1;
      end
      leb_pkg::ST_FINISH: ctl_o.finish = 1'b1;
      default: ;
    endcase
  end
endmodule
`default_nettype wire

// ----- src/leb_dp.sv -----
`timescale 1ns / 1ps
`default_nettype none
module leb_dp (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic [3:0]             kind_i,
  input  wire logic [7:0]             char_code_i,
  input  wire logic                   max_len_we_i,
  input  wire logic [6:0]             max_len_i,
  input  wire leb_pkg::ctl_t          ctl_i,
  output leb_pkg::sts_t               sts_o,
  output logic                        res_valid_o,
  output logic                        changed_o,
  output logic [leb_pkg::PosW-1:0]    cursor_pos_o,
  output logic [leb_pkg::PosW-1:0]    text_len_o,
  output logic [7:0]                  char_out_o,
  output logic                        last_o
);
  logic [7:0]    mem_q [leb_pkg::LineMax];
  logic [7:0]    rd_q;
  leb_pkg::pos_t len_q, cur_q, max_q, p_q, dist_q, end_q;
  leb_pkg::pos_t ncur_q, nlen_q;
  logic          nchg_q;
  logic [3:0]    kind_q;
  logic [7:0]    ch_q;
  logic          ov_q, chg_q, last_q;
  leb_pkg::pos_t ocur_q, olen_q;
  logic [7:0]    och_q;

  logic printable, ins_ok, last_char;
  assign printable = (ch_q >= 8'h20) && (ch_q <= 8'h7E);
  assign ins_ok    = printable && (len_q < max_q);
  assign last_char = (p_q + leb_pkg::PosOne) >= len_q;

  // One read and one write port on the text store.
  leb_pkg::pos_t raddr_w, waddr_w;
  logic [7:0]    wdata_w;
  logic          rd_en, wr_en;

  always_comb begin
    if (ctl_i.rd_left) raddr_w = p_q - leb_pkg::PosOne;
    else if (ctl_i.rd_far) raddr_w = p_q + dist_q;
    else raddr_w = p_q;
  end

  assign rd_en   = ctl_i.rd_left || ctl_i.rd_here || ctl_i.rd_far;
  assign wr_en   = ctl_i.shift_up || ctl_i.shift_dn || ctl_i.write_ch;
  assign waddr_w = ctl_i.write_ch ? cur_q : p_q;
  assign wdata_w = ctl_i.write_ch ? ch_q : rd_q;

  always_ff @(posedge clk_i) begin
    if (rd_en) rd_q <= mem_q[raddr_w[leb_pkg::AddrW-1:0]];
    if (wr_en) mem_q[waddr_w[leb_pkg::AddrW-1:0]] <= wdata_w;
  end

  // Pointers and next cursor/length for the latched command.
  leb_pkg::pos_t p_set, ncur_set, nlen_set, dist_set, end_set;
  logic          nchg_set;

  always_comb begin
    p_set    = cur_q;
    ncur_set = cur_q;
    nlen_set = len_q;
    dist_set = '0;
    end_set  = len_q;
    nchg_set = 1'b0;
    case (kind_q)
      leb_pkg::KIND_INSERT: if (ins_ok) begin
        p_set    = len_q;
        ncur_set = cur_q + leb_pkg::PosOne;
        nlen_set = len_q + leb_pkg::PosOne;
        nchg_set = 1'b1;
      end
      leb_pkg::KIND_LEFT: if (cur_q != '0) ncur_set = cur_q - leb_pkg::PosOne;
      leb_pkg::KIND_RIGHT: if (cur_q < len_q) ncur_set = cur_q + leb_pkg::PosOne;
      leb_pkg::KIND_HOME: ncur_set = '0;
      leb_pkg::KIND_END: ncur_set = len_q;
      leb_pkg::KIND_DEL: if (cur_q < len_q) begin
        dist_set = leb_pkg::PosOne;
        end_set  = len_q - leb_pkg::PosOne;
        nlen_set = len_q - leb_pkg::PosOne;
        nchg_set = 1'b1;
      end
      leb_pkg::KIND_BKSP: if (cur_q != '0) begin
        p_set    = cur_q - leb_pkg::PosOne;
        dist_set = leb_pkg::PosOne;
        end_set  = len_q - leb_pkg::PosOne;
        ncur_set = cur_q - leb_pkg::PosOne;
        nlen_set = len_q - leb_pkg::PosOne;
        nchg_set = 1'b1;
      end
      leb_pkg::KIND_KILLEND: if (cur_q < len_q) begin
        nlen_set = cur_q;
        nchg_set = 1'b1;
      end
      leb_pkg::KIND_KILLSTART: if (cur_q != '0) begin
        p_set    = '0;
        dist_set = cur_q;
        end_set  = len_q - cur_q;
        ncur_set = '0;
        nlen_set = len_q - cur_q;
        nchg_set = 1'b1;
      end
      leb_pkg::KIND_CLEAR: begin
        ncur_set = '0;
        nlen_set = '0;
        nchg_set = (len_q != '0);
      end
      leb_pkg::KIND_READOUT: p_set = '0;
      default: ;
    endcase
  end

  // Width of the word cut found by a leftward scan.
  leb_pkg::pos_t span_w;
  assign span_w = cur_q - p_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q  <= '0;
      cur_q  <= '0;
      max_q  <= leb_pkg::PosMax;
      p_q    <= '0;
      dist_q <= '0;
      end_q  <= '0;
      kind_q <= '0;
      ch_q   <= '0;
      ncur_q <= '0;
      nlen_q <= '0;
      nchg_q <= 1'b0;
    end else begin
      if (max_len_we_i)
        max_q <= (max_len_i != 7'd0 && max_len_i <= leb_pkg::PosMax)
                 ? max_len_i : leb_pkg::PosMax;
      if (ctl_i.load) begin
        kind_q <= kind_i;
        ch_q   <= char_code_i;
      end
      if (ctl_i.setup) begin
        p_q    <= p_set;
        ncur_q <= ncur_set;
        nlen_q <= nlen_set;
        nchg_q <= nchg_set;
        dist_q <= dist_set;
        end_q  <= end_set;
      end else if (ctl_i.cut_setup) begin
        // An empty cut ends the gap closing at once.
        dist_q <= span_w;
        end_q  <= (span_w == '0) ? p_q : len_q - span_w;
        ncur_q <= p_q;
        nlen_q <= len_q - span_w;
        nchg_q <= (span_w != '0);
      end else if (ctl_i.take_p) begin
        ncur_q <= p_q;
      end else if (ctl_i.step_dn || ctl_i.shift_up) begin
        p_q <= p_q - leb_pkg::PosOne;
      end else if (ctl_i.step_up || ctl_i.shift_dn || ctl_i.emit_char) begin
        p_q <= p_q + leb_pkg::PosOne;
      end
      if (ctl_i.finish) begin
        cur_q <= ncur_q;
        len_q <= nlen_q;
      end
    end
  end

  // Result register for one beat.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q   <= 1'b0;
      chg_q  <= 1'b0;
      ocur_q <= '0;
      olen_q <= '0;
      och_q  <= 8'h00;
      last_q <= 1'b0;
    end else if (ctl_i.finish) begin
      ov_q   <= 1'b1;
      chg_q  <= nchg_q;
      ocur_q <= ncur_q;
      olen_q <= nlen_q;
      och_q  <= 8'h00;
      last_q <= 1'b1;
    end else if (ctl_i.emit_char) begin
      ov_q   <= 1'b1;
      chg_q  <= 1'b0;
      ocur_q <= cur_q;
      olen_q <= len_q;
      och_q  <= rd_q;
      last_q <= last_char;
    end else begin
      ov_q <= 1'b0;
    end
  end

  assign res_valid_o  = ov_q;
  assign changed_o    = chg_q;
  assign cursor_pos_o = ocur_q;
  assign text_len_o   = olen_q;
  assign char_out_o   = och_q;
  assign last_o       = last_q;

  assign sts_o.kind          = kind_q;
  assign sts_o.p_zero        = (p_q == '0);
  assign sts_o.p_at_len      = (p_q == len_q);
  assign sts_o.rd_ws         = leb_pkg::is_ws(rd_q);
  assign sts_o.shift_end     = (p_q >= end_q);
  assign sts_o.up_end        = (p_q == cur_q);
  assign sts_o.ins_ok        = ins_ok;
  assign sts_o.need_shift_dn = (kind_q == leb_pkg::KIND_DEL) ? (cur_q < len_q)
                             : (cur_q != '0);
  assign sts_o.len_zero      = (len_q == '0);
  assign sts_o.last_char     = last_char;

  assert property (@(posedge clk_i) disable iff (!rst_ni) cur_q <= len_q)
    else $error("cursor beyond length");
  assert property (@(posedge clk_i) disable iff (!rst_ni) len_q <= leb_pkg::PosMax)
    else $error("length beyond line size");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   max_q != '0 && max_q <= leb_pkg::PosMax)
    else $error("line limit out of range");
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(ctl_i.finish && ctl_i.emit_char))
    else $error("two result sources at once");
endmodule
`default_nettype wire

// ----- bench/line_edit_buffer_engine_tb.sv -----
`timescale 1ns / 1ps
module line_edit_buffer_engine_tb;
  typedef struct packed {
    logic       changed;
    logic [6:0] cursor_pos;
    logic [6:0] text_len;
    logic [7:0] char_out;
    logic       last;
  } edit_beat_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       start = 1'b0;
  logic       busy;
  logic [3:0] kind_i = leb_pkg::KIND_HOME;
  logic [7:0] char_code_i = 8'h00;
  logic       max_len_we_i = 1'b0;
  logic [6:0] max_len_i = 7'd0;
  logic       result_valid_o;
  logic       changed_o;
  logic [6:0] cursor_pos_o;
  logic [6:0] text_len_o;
  logic [7:0] char_out_o;
  logic       last_o;

  // Mirror of the line held by the block.
  logic [7:0] line_text [leb_pkg::LineMax];
  int         line_len = 0;
  int         line_cur = 0;
  int         line_cap = leb_pkg::LineMax;
  edit_beat_t pending_beats [$];
  int         fail_count = 0;

  line_edit_buffer_engine dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
    .kind_i(kind_i), .char_code_i(char_code_i),
    .max_len_we_i(max_len_we_i), .max_len_i(max_len_i),
    .result_valid_o(result_valid_o), .changed_o(changed_o),
    .cursor_pos_o(cursor_pos_o), .text_len_o(text_len_o),
    .char_out_o(char_out_o), .last_o(last_o)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #20ms;
    $display("FAIL");
    $finish;
  end

  function automatic bit is_blank(input logic [7:0] c);
    return (c >= 8'h09 && c <= 8'h0D) || c == 8'h20;
  endfunction

  function automatic int word_start();
    int p;
    p = line_cur;
    while (p > 0 && is_blank(line_text[p-1])) p--;
    while (p > 0 && !is_blank(line_text[p-1])) p--;
    return p;
  endfunction

  // Remove characters [from, upto) and close the gap.
  task automatic cut_span(input int from, input int upto);
    for (int i = from; i < line_len - (upto - from); i++)
      line_text[i] = line_text[i + upto - from];
    line_len -= upto - from;
  endtask

  task automatic push_beat(input bit chg, input logic [7:0] ch, input bit lst);
    pending_beats.push_back({chg, 7'(line_cur), 7'(line_len), ch, lst});
  endtask

  task automatic apply_edit(input leb_pkg::kind_e k, input logic [7:0] c);
    bit chg;
    int p;
    chg = 0;
    case (k)
      leb_pkg::KIND_INSERT: if (c >= 8'h20 && c <= 8'h7E && line_len < line_cap) begin
        for (int i = line_len; i > line_cur; i--) line_text[i] = line_text[i-1];
        line_text[line_cur] = c;
        line_cur++;
        line_len++;
        chg = 1;
      end
      leb_pkg::KIND_LEFT: if (line_cur > 0) line_cur--;
      leb_pkg::KIND_RIGHT: if (line_cur < line_len) line_cur++;
      leb_pkg::KIND_HOME: line_cur = 0;
      leb_pkg::KIND_END: line_cur = line_len;
      leb_pkg::KIND_WLEFT: line_cur = word_start();
      leb_pkg::KIND_WRIGHT: begin
        p = line_cur;
        while (p < line_len && !is_blank(line_text[p])) p++;
        while (p < line_len && is_blank(line_text[p])) p++;
        line_cur = p;
      end
      leb_pkg::KIND_DEL: if (line_cur < line_len) begin
        cut_span(line_cur, line_cur + 1);
        chg = 1;
      end
      leb_pkg::KIND_BKSP: if (line_cur > 0) begin
        cut_span(line_cur - 1, line_cur);
        line_cur--;
        chg = 1;
      end
      leb_pkg::KIND_DELWORD: begin
        p = word_start();
        if (p != line_cur) begin
          cut_span(p, line_cur);
          line_cur = p;
          chg = 1;
        end
      end
      leb_pkg::KIND_KILLEND: if (line_cur < line_len) begin
        line_len = line_cur;
        chg = 1;
      end
      leb_pkg::KIND_KILLSTART: if (line_cur > 0) begin
        cut_span(0, line_cur);
        line_cur = 0;
        chg = 1;
      end
      leb_pkg::KIND_CLEAR: begin
        chg = line_len != 0;
        line_len = 0;
        line_cur = 0;
      end
      default: ;
    endcase
    if (k == leb_pkg::KIND_READOUT) begin
      if (line_len == 0) push_beat(0, 8'h00, 1);
      for (int i = 0; i < line_len; i++) push_beat(0, line_text[i], i == line_len - 1);
    end else begin
      push_beat(chg, 8'h00, 1);
    end
  endtask

  always @(posedge clk_i) begin
    edit_beat_t want;
    edit_beat_t got;
    if (result_valid_o) begin
      got = {changed_o, cursor_pos_o, text_len_o, char_out_o, last_o};
      if (pending_beats.size() == 0) begin
        $display("%0t: unexpected beat %h", $time, got);
        fail_count++;
      end else begin
        want = pending_beats.pop_front();
        if (want.changed !== got.changed) begin
          $display("%0t: changed exp %0d got %0d", $time, want.changed, got.changed);
          fail_count++;
        end
        if (want.cursor_pos !== got.cursor_pos) begin
          $display("%0t: cursor exp %0d got %0d", $time, want.cursor_pos, got.cursor_pos);
          fail_count++;
        end
        if (want.text_len !== got.text_len) begin
          $display("%0t: length exp %0d got %0d", $time, want.text_len, got.text_len);
          fail_count++;
        end
        if (want.char_out !== got.char_out) begin
          $display("%0t: char exp %h got %h", $time, want.char_out, got.char_out);
          fail_count++;
        end
        if (want.last !== got.last) begin
          $display("%0t: last exp %0d got %0d", $time, want.last, got.last);
          fail_count++;
        end
      end
    end
  end

  // Start stays high after a beat; only an idle gap or a drain lowers it. Busy is
  // stable at the falling edge, so the next rising edge is the accepting one.
  task automatic send_cmd(input leb_pkg::kind_e k, input logic [7:0] c);
    @(negedge clk_i);
    start = 1'b1;
    kind_i = k;
    char_code_i = c;
    while (busy) @(negedge clk_i);
    @(posedge clk_i);
    apply_edit(k, c);
  endtask

  task automatic idle_gap();
    int n;
    n = $urandom_range(0, 99);
    if (n < 55) n = 0;
    else if (n < 90) n = $urandom_range(1, 3);
    else n = $urandom_range(10, 40);
    if (n > 0) begin
      @(negedge clk_i);
      start = 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    @(negedge clk_i);
    start = 1'b0;
    while (pending_beats.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
  endtask

  task automatic write_max_len(input logic [6:0] v);
    drain();
    @(negedge clk_i);
    max_len_we_i = 1'b1;
    max_len_i = v;
    @(negedge clk_i);
    max_len_we_i = 1'b0;
    line_cap = (v > 0 && v <= leb_pkg::LineMax) ? int'(v) : leb_pkg::LineMax;
  endtask

  task automatic test_directed();
    send_cmd(leb_pkg::KIND_READOUT, 8'hFF);
    send_cmd(leb_pkg::KIND_BKSP, 8'h00);
    send_cmd(leb_pkg::KIND_DELWORD, 8'h00);
    send_cmd(leb_pkg::KIND_CLEAR, 8'h00);
    send_cmd(leb_pkg::KIND_INSERT, 8'h20);
    send_cmd(leb_pkg::KIND_INSERT, 8'h7E);
    send_cmd(leb_pkg::KIND_INSERT, 8'h1F);
    send_cmd(leb_pkg::KIND_INSERT, 8'h7F);
    send_cmd(leb_pkg::KIND_INSERT, 8'hFF);
    send_cmd(leb_pkg::KIND_INSERT, 8'h41);
    send_cmd(leb_pkg::KIND_INSERT, 8'h20);
    send_cmd(leb_pkg::KIND_INSERT, 8'h62);
    for (int k = 1; k < 16; k++) send_cmd(leb_pkg::kind_e'(k), 8'hA5);
  endtask

  // A line that is full, and a cap lowered below the current length.
  task automatic test_cap_limits();
    write_max_len(7'd1);
    send_cmd(leb_pkg::KIND_INSERT, 8'h58);
    send_cmd(leb_pkg::KIND_INSERT, 8'h59);
    send_cmd(leb_pkg::KIND_READOUT, 8'h00);
    write_max_len(7'd64);
    repeat (66) send_cmd(leb_pkg::KIND_INSERT, 8'($urandom_range(8'h20, 8'h7E)));
    send_cmd(leb_pkg::KIND_READOUT, 8'h00);
    write_max_len(7'd10);
    send_cmd(leb_pkg::KIND_INSERT, 8'h51);
    send_cmd(leb_pkg::KIND_KILLSTART, 8'h00);
    send_cmd(leb_pkg::KIND_INSERT, 8'h52);
    write_max_len(7'd0);
    write_max_len(7'd127);
  endtask

  task automatic test_random(input int count);
    int r;
    logic [7:0] c;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (r < 50) begin
        r = $urandom_range(0, 9);
        if (r < 3) c = 8'h20;
        else if (r < 9) c = 8'($urandom_range(8'h21, 8'h7E));
        else c = 8'($urandom);
        send_cmd(leb_pkg::KIND_INSERT, c);
      end else if (r < 56) begin
        send_cmd(leb_pkg::KIND_READOUT, 8'($urandom));
      end else if (r < 58) begin
        send_cmd(leb_pkg::KIND_CLEAR, 8'($urandom));
      end else begin
        send_cmd(leb_pkg::kind_e'($urandom_range(1, 15)), 8'($urandom));
      end
      idle_gap();
    end
  endtask

  initial begin
    for (int i = 0; i < leb_pkg::LineMax; i++) line_text[i] = 8'h00;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_directed();
    test_cap_limits();
    write_max_len(7'd64);
    test_random(80);
    write_max_len(7'd5);
    test_random(40);
    write_max_len(7'($urandom_range(1, 64)));
    test_random(40);
    write_max_len(7'd64);
    test_random(50);
    drain();
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
